### rtl/bgcd_pkg.sv
// ---------------------------------------------------------------------------
// bgcd_pkg
// Shared widths and controller/datapath interface types for binary_gcd.
// ---------------------------------------------------------------------------
`default_nettype none

package bgcd_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int IN_W  = 2 * WIDTH;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic equal;
    } t_dp_sts;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

endpackage

`default_nettype wire

### rtl/bgcd_dp.sv
// ---------------------------------------------------------------------------
// bgcd_dp
// Datapath: operand registers, shared-trailing-zero counter, one binary
// GCD step per cycle, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bgcd_dp
    import bgcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [WIDTH-1:0] i_a_value,
    input  wire logic [WIDTH-1:0] i_b_value,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output logic [WIDTH-1:0]      o_gcd_value
);

    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [CNT_W-1:0] r_k, n_k;
    logic [WIDTH-1:0] r_result;

    logic [WIDTH:0]   diff_xy;
    logic [WIDTH:0]   diff_yx;
    logic             zero_in;

    assign diff_xy = {1'b0, r_x} - {1'b0, r_y};
    assign diff_yx = {1'b0, r_y} - {1'b0, r_x};
    assign zero_in = (i_a_value == '0) || (i_b_value == '0);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        if (i_cmd.load) begin
            // a zero operand collapses both registers to a|b: already equal
            if (zero_in) begin
                n_x = i_a_value | i_b_value;
                n_y = i_a_value | i_b_value;
            end else begin
                n_x = i_a_value;
                n_y = i_b_value;
            end
            n_k = '0;
        end else if (i_cmd.step) begin
            if (!r_x[0] && !r_y[0]) begin
                n_x = r_x >> 1;
                n_y = r_y >> 1;
                n_k = r_k + CNT_W'(1);
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (!diff_xy[WIDTH]) begin
                n_x = diff_xy[WIDTH-1:0] >> 1;
            end else begin
                n_y = diff_yx[WIDTH-1:0] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
        if (i_cmd.capture) begin
            r_result <= r_x << r_k;
        end
    end

    assign o_sts.equal = (r_x == r_y);
    assign o_gcd_value = r_result;

endmodule

`default_nettype wire

### rtl/bgcd_ctrl.sv
// ---------------------------------------------------------------------------
// bgcd_ctrl
// Controller: one item in flight, datapath sequencing, output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   out_free;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load    = in_fire;
        o_cmd.step    = (r_state == ST_BUSY) && !i_sts.equal;
        o_cmd.capture = (r_state == ST_BUSY) && i_sts.equal && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (o_cmd.capture) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_valid)
        else $error("captured result not presented");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_BUSY))
        else $error("accepted item did not start");

    a_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> (r_state == ST_BUSY))
        else $error("left busy before operands matched");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.capture)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/binary_gcd.sv
// ---------------------------------------------------------------------------
// binary_gcd
// Greatest common divisor of two unsigned operands, binary (Stein) method.
//
// Channel   Dir  tdata fields (low bit up)
// s_axis    in   a_value[63:0], b_value[127:64]
// m_axis    out  gcd_value[63:0]
//
// One item at a time; the GCD step unit does one halve or subtract-and-halve
// per cycle. A zero operand loads both registers equal and needs no steps.
// The result register lets the next item start while a result waits.
// Synchronous active-low reset clears control only.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_gcd
    import bgcd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [IN_W-1:0] i_s_axis_tdata,  // a_value, b_value
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic [WIDTH-1:0]     o_m_axis_tdata   // gcd_value
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bgcd_dp u_dp (
        .i_clk       (i_clk),
        .i_a_value   (i_s_axis_tdata[WIDTH-1:0]),
        .i_b_value   (i_s_axis_tdata[IN_W-1:WIDTH]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_gcd_value (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks binary_gcd against a Stein's-method GCD predictor. Operand pairs go
// in through the input stream and GCD results come out of the output stream.
// Both sides pause at random, with some runs of back-to-back transfers. A
// scoreboard keeps the expected GCD of each accepted item in order and
// compares it with each result.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import bgcd_pkg::*;

    localparam int NUM_RANDOM  = 1200;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 4 * WIDTH + 16;

    typedef logic [WIDTH-1:0] t_word;

    class gcd_scoreboard;
        t_word gcd_queue[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function t_word odd_part(input t_word v);
            t_word r;
            r = v;
            while (!r[0]) r = r >> 1;
            return r;
        endfunction

        static function t_word predict_gcd(input t_word a, input t_word b);
            t_word u, v, t;
            int    shared_tz;
            if (a == '0 || b == '0) return a | b;
            t = a | b;
            shared_tz = 0;
            while (!t[shared_tz]) shared_tz++;
            u = odd_part(a);
            v = odd_part(b);
            while (u != v) begin
                if (u < v) begin
                    t = u;
                    u = v;
                    v = t;
                end
                u = odd_part(u - v);
            end
            return u << shared_tz;
        endfunction

        function void note_operands(input t_word a, input t_word b);
            gcd_queue = {gcd_queue, predict_gcd(a, b)};
        endfunction

        function void check_gcd(input t_word actual);
            t_word want;
            if (gcd_queue.size() == 0) begin
                $display("%0t: unexpected result gcd_value=%h", $time, actual);
                errors++;
            end else begin
                want = gcd_queue.pop_front();
                if (want !== actual) begin
                    $display("%0t: gcd_value mismatch expected=%h actual=%h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return gcd_queue.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // a_value, b_value
    logic              m_tvalid;
    logic              m_tready;
    logic [WIDTH-1:0]  m_tdata;   // gcd_value

    gcd_scoreboard sb;
    int            cycles = 0;

    binary_gcd dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // gap per item; quiet stretches give back-to-back transfers
    function automatic int draw_gap(input int idx, input bit quiet_even);
        bit quiet;
        quiet = ((idx / 64) % 2 == 0) ? quiet_even : !quiet_even;
        if (quiet && (idx % 64) < 24) return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic send_operands(input t_word a, input t_word b, input int idx);
        int gap;
        gap = draw_gap(idx, 1'b1);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge i_clk); while (!s_tready);
        sb.note_operands(a, b);
    endtask

    task automatic drain_results();
        int gap;
        int idx;
        idx = 0;
        forever begin
            gap = draw_gap(idx, 1'b0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_gcd(m_tdata);
            idx++;
        end
    endtask

    task automatic send_random(input int idx);
        t_word a, b, g;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                a = rand_word();
                b = rand_word();
            end
            3, 4, 5: begin
                // shared factor with many trailing zeros
                g = t_word'($urandom) << $urandom_range(0, 48);
                a = g * t_word'($urandom_range(1, 1 << 16));
                b = g * t_word'($urandom_range(1, 1 << 16));
            end
            6: begin
                a = t_word'($urandom_range(0, 255));
                b = t_word'($urandom_range(0, 255));
            end
            7: begin
                a = rand_word() >> $urandom_range(0, 63);
                b = '0;
                if ($urandom_range(0, 1)) begin
                    b = a;
                    a = '0;
                end
            end
            default: begin
                a = rand_word() << $urandom_range(0, 63);
                b = rand_word() << $urandom_range(0, 63);
            end
        endcase
        send_operands(a, b, idx);
    endtask

    initial begin
        t_word da[$];
        t_word db[$];
        int    n;
        sb       = new();
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            drain_results();
        join_none

        // zero operands, extremes, full-width shared trailing zeros
        da = '{64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
               64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0300_0000_0000,
               64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000,
               64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_0006,
               64'h5555_5555_5555_5555, 64'h0000_0000_0000_0001,
               64'hC000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF,
               64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_000C};
        db = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
               64'h4000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE,
               64'h0000_0500_0000_0000, 64'h0, 64'h0000_0002_0000_0000,
               64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0009,
               64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0001,
               64'h4000_0000_0000_0000, 64'h0000_0001_0000_0000,
               64'h0000_0000_0000_0001, 64'h0000_0000_0000_0012};
        for (n = 0; n < da.size(); n++) send_operands(da[n], db[n], n);

        for (n = 0; n < NUM_RANDOM; n++) send_random(n + da.size());
        s_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
